[rtl/mfsf_pkg.sv]
// Shared types, command codes and the row mask function of the framebuffer fill engine.
package mfsf_pkg;

  localparam int unsigned CoordW = 10;

  typedef enum logic [3:0] {
    CMD_CLEAR     = 4'd0,
    CMD_FILL      = 4'd1,
    CMD_OUTLINE   = 4'd2,
    CMD_RIGHT_TRI = 4'd3,
    CMD_LEFT_TRI  = 4'd4,
    CMD_UP_TRI    = 4'd5,
    CMD_DOWN_TRI  = 4'd6,
    CMD_READ      = 4'd7,
    CMD_ACK       = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic       color;
  } draw_cmd_t;

  // One column to update: its address and the run of rows to cover.
  typedef struct packed {
    logic              valid;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] count;
  } col_item_t;

  // Bits for rows top .. top+count-1, clipped to rows; row 0 is bit 31.
  function automatic logic [31:0] row_mask(logic [CoordW-1:0] top, logic [CoordW-1:0] count,
                                           logic [5:0] rows);
    logic [CoordW:0] end_row;
    logic [31:0]     m;
    m       = 32'h0000_0000;
    end_row = {1'b0, top} + {1'b0, count};
    if (count != '0 && top < {4'b0, rows}) begin
      if (end_row > {5'b0, rows}) begin
        end_row = {5'b0, rows};
      end
      m = 32'hFFFF_FFFF >> top[4:0];
      if (end_row < 11'd32) begin
        m = m & ~(32'hFFFF_FFFF >> end_row[4:0]);
      end
    end
    return m;
  endfunction

endpackage

[rtl/mfsf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mfsf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mfsf_sweep.sv]
// Column walker: steps through the columns of a draw command and works out each row run.
module mfsf_sweep #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned ROWS    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mfsf_pkg::draw_cmd_t cmd_i,
  output logic               busy_o,
  output mfsf_pkg::col_item_t item_o
);

  localparam int unsigned CW = mfsf_pkg::CoordW;

  logic                busy_q, busy_d;
  logic [8:0]          j_q, j_d;
  mfsf_pkg::col_item_t item_q, item_d;

  logic [8:0]    n;
  logic [CW-1:0] j10, x10, y10, w10, h10, hh, hw, wm1j, k, col, top, count;
  logic          emit;

  always_comb begin
    j10  = {1'b0, j_q};
    x10  = {2'b0, cmd_i.x};
    y10  = {2'b0, cmd_i.y};
    w10  = {2'b0, cmd_i.w};
    h10  = {2'b0, cmd_i.h};
    hh   = {3'b0, cmd_i.h[7:1]};
    hw   = {3'b0, cmd_i.w[7:1]};
    wm1j = w10 - 10'd1 - j10;
    k    = (j10 < wm1j) ? j10 : wm1j;
    col  = x10 + j10;
    n    = 9'd0;
    top  = y10;
    count = h10;
    case (cmd_i.cmd)
      mfsf_pkg::CMD_CLEAR: begin
        n     = 9'(COLUMNS);
        col   = j10;
        top   = '0;
        count = CW'(ROWS);
      end
      mfsf_pkg::CMD_FILL: begin
        n = {1'b0, cmd_i.w};
      end
      mfsf_pkg::CMD_OUTLINE: begin
        n     = (cmd_i.w != 8'd0 && cmd_i.h != 8'd0) ? {1'b0, cmd_i.w} : 9'd0;
        count = (j10 == '0 || j10 == w10 - 10'd1) ? h10 : 10'd1;
      end
      mfsf_pkg::CMD_RIGHT_TRI: begin
        n     = {2'b0, cmd_i.h[7:1]} + 9'd1;
        top   = y10 + j10 + {9'b0, cmd_i.h[0]};
        count = ((hh - j10) << 1) + 10'd1;
      end
      mfsf_pkg::CMD_LEFT_TRI: begin
        n     = {2'b0, cmd_i.h[7:1]} + 9'd1;
        top   = y10 + hh + {9'b0, cmd_i.h[0]} - j10;
        count = (j10 << 1) + 10'd1;
      end
      mfsf_pkg::CMD_UP_TRI: begin
        n     = {1'b0, cmd_i.w};
        top   = y10 + hw - k;
        count = k + 10'd1;
      end
      mfsf_pkg::CMD_DOWN_TRI: begin
        n     = {1'b0, cmd_i.w};
        count = k + 10'd1;
      end
      default: begin
        n = 9'd0;
      end
    endcase
    // Stop at the first column past the right edge: later ones are clipped too.
    emit = busy_q && (j_q < n) && (col < CW'(COLUMNS));
  end

  always_comb begin
    busy_d       = busy_q;
    j_d          = j_q;
    item_d.valid = emit;
    item_d.col   = col;
    item_d.top   = top;
    item_d.count = count;
    if (start_i) begin
      busy_d = 1'b1;
      j_d    = '0;
    end else if (busy_q) begin
      if (emit) begin
        j_d = j_q + 9'd1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      j_q    <= '0;
      item_q <= '0;
    end else begin
      busy_q <= busy_d;
      j_q    <= j_d;
      item_q <= item_d;
    end
  end

  assign busy_o = busy_q;
  assign item_o = item_q;

endmodule

[rtl/mfsf_rmw.sv]
// Column store with per-column valid bits and the masked read-modify-write stage.
module mfsf_rmw #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned ROWS    = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mfsf_pkg::col_item_t        item_i,
  input  logic                       outline_i,
  input  logic [mfsf_pkg::CoordW-1:0] bot_row_i,
  input  logic                       color_i,
  input  logic                       rd_req_i,
  input  logic [$clog2(COLUMNS)-1:0] rd_addr_i,
  output logic                       busy_o,
  output logic [31:0]                rd_word_o
);

  localparam int unsigned AW = $clog2(COLUMNS);

  logic [COLUMNS-1:0] vbit_q, vbit_d;
  logic               vbit_rd_q;
  logic               s1_valid_q;
  logic [AW-1:0]      s1_addr_q;
  logic [31:0]        s1_mask_q;

  logic [AW-1:0] raddr;
  logic [31:0]   mask, ram_rdata, old_word, wdata;

  always_comb begin
    raddr = item_i.valid ? item_i.col[AW-1:0] : rd_addr_i;
    mask  = mfsf_pkg::row_mask(item_i.top, item_i.count, 6'(ROWS));
    if (outline_i) begin
      mask = mask | mfsf_pkg::row_mask(bot_row_i, 10'd1, 6'(ROWS));
    end
  end

  mfsf_ram #(
    .WIDTH(32),
    .DEPTH(COLUMNS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_addr_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // A column never written reads as all zeros.
  assign old_word = vbit_rd_q ? ram_rdata : 32'h0000_0000;
  assign wdata    = color_i ? (old_word & ~s1_mask_q) : (old_word | s1_mask_q);

  always_comb begin
    vbit_d = vbit_q;
    if (s1_valid_q) begin
      vbit_d[s1_addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbit_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      vbit_q     <= vbit_d;
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    vbit_rd_q <= vbit_q[raddr];
    s1_addr_q <= item_i.col[AW-1:0];
    s1_mask_q <= mask;
  end

  assign busy_o    = s1_valid_q;
  assign rd_word_o = rd_req_i ? 32'h0000_0000 : old_word;

endmodule

[rtl/mono_framebuffer_shape_fill_core.sv]
// Top level of the one-bit framebuffer fill engine: command control, result register.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_ready_o  | command, x, y, width, height, color
//  out     | output    | out_valid_o / out_ready_i| column_word, refresh_pending
//
// A draw command streams its columns, one per cycle, through the walker, the mask and
// read stage and the write stage of the column store, then passes done and idle. A read
// passes a read state and a wait state for the registered store, then done; a read past
// the width, an acknowledge or an unused code goes straight to done. Reset is immediate:
// per-column valid bits make unwritten columns read as zero, so no clearing pass runs.
// The result sits in an output register, so a new transaction is taken while an earlier
// result waits; a command whose result cannot yet be loaded holds the engine until the
// output slot frees.
module mono_framebuffer_shape_fill_core #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned ROWS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  command_i,
  input  logic [7:0]  x_i,
  input  logic [7:0]  y_i,
  input  logic [7:0]  width_i,
  input  logic [7:0]  height_i,
  input  logic        color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] column_word_o,
  output logic        refresh_pending_o
);

  localparam int unsigned AW = $clog2(COLUMNS);
  localparam int unsigned CW = mfsf_pkg::CoordW;

  mfsf_pkg::state_e    state_q, state_d;
  mfsf_pkg::draw_cmd_t cmd_q, cmd_d, in_cmd;
  logic [31:0]         word_q, word_d;
  logic                dirty_q, dirty_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         out_word_q, out_word_d;
  logic                out_dirty_q, out_dirty_d;

  logic                accept, sweep_start, rd_req, load_out, is_draw;
  logic                sweep_busy, rmw_busy;
  mfsf_pkg::col_item_t item;
  logic [31:0]         rd_word;
  logic [CW-1:0]       bot_row;

  always_comb begin
    in_cmd.cmd   = mfsf_pkg::cmd_e'(command_i);
    in_cmd.x     = x_i;
    in_cmd.y     = y_i;
    in_cmd.w     = width_i;
    in_cmd.h     = height_i;
    in_cmd.color = color_i;
    is_draw      = in_cmd.cmd inside {[mfsf_pkg::CMD_CLEAR : mfsf_pkg::CMD_DOWN_TRI]};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfsf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (is_draw) begin
            state_d = mfsf_pkg::ST_SWEEP;
          end else if (in_cmd.cmd == mfsf_pkg::CMD_READ && {2'b0, x_i} < CW'(COLUMNS)) begin
            state_d = mfsf_pkg::ST_READ;
          end else begin
            state_d = mfsf_pkg::ST_DONE;
          end
        end
      end
      mfsf_pkg::ST_SWEEP: begin
        // Wait until the walker is spent and the last write has landed.
        if (!sweep_busy && !item.valid && !rmw_busy) begin
          state_d = mfsf_pkg::ST_DONE;
        end
      end
      mfsf_pkg::ST_READ:      state_d = mfsf_pkg::ST_READ_WAIT;
      mfsf_pkg::ST_READ_WAIT: state_d = mfsf_pkg::ST_DONE;
      mfsf_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = mfsf_pkg::ST_IDLE;
        end
      end
      default: state_d = mfsf_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    rd_req      = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      mfsf_pkg::ST_IDLE:  in_ready_o = 1'b1;
      mfsf_pkg::ST_READ:  rd_req     = 1'b1;
      mfsf_pkg::ST_DONE:  load_out   = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    accept      = in_valid_i && in_ready_o;
    sweep_start = accept && is_draw;
  end

  // Command payload, read word and dirty flag.
  always_comb begin
    cmd_d   = cmd_q;
    word_d  = word_q;
    dirty_d = dirty_q;
    if (accept) begin
      cmd_d  = in_cmd;
      word_d = 32'h0000_0000;
      if (is_draw) begin
        dirty_d = 1'b1;
      end else if (in_cmd.cmd == mfsf_pkg::CMD_ACK) begin
        dirty_d = 1'b0;
      end
    end
    if (state_q == mfsf_pkg::ST_READ_WAIT) begin
      word_d = rd_word;
    end
  end

  // Output register: load when the slot is empty or being drained.
  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_dirty_d = out_dirty_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_word_d  = word_q;
      out_dirty_d = dirty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfsf_pkg::ST_IDLE;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    word_q      <= word_d;
    out_word_q  <= out_word_d;
    out_dirty_q <= out_dirty_d;
  end

  // Bottom edge row of an outline, added to every column's mask.
  assign bot_row = {2'b0, cmd_q.y} + {2'b0, cmd_q.h} - 10'd1;

  mfsf_sweep #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_sweep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sweep_start),
    .cmd_i  (cmd_q),
    .busy_o (sweep_busy),
    .item_o (item)
  );

  mfsf_rmw #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_rmw (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .outline_i(cmd_q.cmd == mfsf_pkg::CMD_OUTLINE),
    .bot_row_i(bot_row),
    .color_i  (cmd_q.color),
    .rd_req_i (rd_req),
    .rd_addr_i(cmd_q.x[AW-1:0]),
    .busy_o   (rmw_busy),
    .rd_word_o(rd_word)
  );

  assign out_valid_o       = out_valid_q;
  assign column_word_o     = out_word_q;
  assign refresh_pending_o = out_dirty_q;

  // Column updates only flow while a draw command is being swept.
  a_item_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item.valid |-> state_q == mfsf_pkg::ST_SWEEP)
    else $error("column update outside a sweep");

  // The engine is quiet whenever it offers to take a transaction.
  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mfsf_pkg::ST_IDLE |-> !sweep_busy && !rmw_busy && !item.valid)
    else $error("pipeline busy while idle");

  // An accepted transaction always leaves the idle state.
  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != mfsf_pkg::ST_IDLE)
    else $error("accepted transaction not started");

  // A finished command lands in the output register and frees the engine.
  a_done_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && state_q == mfsf_pkg::ST_IDLE)
    else $error("result not loaded");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the one-bit framebuffer fill engine: table-driven and random commands.
module tb_top;

  localparam int unsigned FB_COLUMNS      = 128;
  localparam int unsigned FB_ROWS         = 32;
  localparam logic [3:0]  FIRST_UNUSED_CMD = 4'd9;
  localparam logic [3:0]  LAST_UNUSED_CMD  = 4'd15;
  localparam int unsigned ITEMS_PER_PHASE = 342;
  localparam int unsigned HOLD_OFF_CYCLES = 400;   // long output back-pressure stretch
  localparam int unsigned TAIL_CYCLES     = 200;   // beyond the slowest command (clear)
  localparam int unsigned STALL_LIMIT     = 4000;  // cycles with no transaction at all
  localparam int unsigned REPORT_LIMIT    = 10;

  // One draw / read / acknowledge command as offered on the input channel.
  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic       color;
  } shape_req_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] word;
    logic        pending;
  } fb_result_t;

  // A row of the directed table; fixed marks a result typed in by hand.
  typedef struct packed {
    shape_req_t req;
    logic       fixed;
    fb_result_t result;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  command_i;
  logic [7:0]  x_i;
  logic [7:0]  y_i;
  logic [7:0]  width_i;
  logic [7:0]  height_i;
  logic        color_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] column_word_o;
  logic        refresh_pending_o;

  // Shadow copy of the frame and the refresh flag, advanced at each accepted command.
  logic [31:0] shadow_fb [FB_COLUMNS];
  logic        shadow_dirty;

  fb_result_t  column_results_q[$];
  table_row_t  directed_q[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct   = 0;
  bit          hold_off_req    = 1'b0;
  int unsigned hold_offs_done  = 0;
  int unsigned fault_count     = 0;
  int unsigned results_checked = 0;
  int unsigned draw_count      = 0;
  int unsigned read_count      = 0;
  int unsigned ack_count       = 0;
  int unsigned unused_count    = 0;

  mono_framebuffer_shape_fill_core #(
    .COLUMNS(FB_COLUMNS),
    .ROWS   (FB_ROWS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .x_i              (x_i),
    .y_i              (y_i),
    .width_i          (width_i),
    .height_i         (height_i),
    .color_i          (color_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .column_word_o    (column_word_o),
    .refresh_pending_o(refresh_pending_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bits for rows top .. top+count-1, clipped to the frame height; row 0 is bit 31.
  function automatic logic [31:0] rows_covered(int unsigned top, int unsigned count);
    int unsigned stop;
    logic [31:0] m;
    if (count == 0 || top >= FB_ROWS) return 32'h0;
    stop = top + count;
    if (stop > FB_ROWS) stop = FB_ROWS;
    m = 32'hFFFF_FFFF >> top;
    if (stop < 32) m = m & ~(32'hFFFF_FFFF >> stop);
    return m;
  endfunction

  // Masked read-modify-write of a block of columns; stop at the right edge.
  function automatic void paint_block(int unsigned x, int unsigned y, int unsigned w,
                                      int unsigned h, logic color);
    logic [31:0] m;
    m = rows_covered(y, h);
    if (m == 32'h0) return;
    for (int unsigned c = 0; c < w; c++) begin
      if (x + c >= FB_COLUMNS) break;
      if (!color) shadow_fb[x + c] = shadow_fb[x + c] | m;
      else shadow_fb[x + c] = shadow_fb[x + c] & ~m;
    end
  endfunction

  // Apply one command to the shadow frame and return the result it must produce.
  function automatic fb_result_t predict_shape_cmd(shape_req_t r);
    fb_result_t  res;
    int unsigned cx, cy, cw, ch, half, start, hw, row;
    res = '0;
    cx  = r.x;
    cy  = r.y;
    cw  = r.w;
    ch  = r.h;
    case (r.cmd)
      mfsf_pkg::CMD_CLEAR: begin
        for (int unsigned c = 0; c < FB_COLUMNS; c++) begin
          shadow_fb[c] = r.color ? 32'h0 : rows_covered(0, FB_ROWS);
        end
        shadow_dirty = 1'b1;
      end
      mfsf_pkg::CMD_FILL: begin
        paint_block(cx, cy, cw, ch, r.color);
        shadow_dirty = 1'b1;
      end
      mfsf_pkg::CMD_OUTLINE: begin
        // Zero width or height draws nothing but still marks the frame dirty.
        if (cw != 0 && ch != 0) begin
          paint_block(cx, cy, cw, 1, r.color);
          paint_block(cx + cw - 1, cy, 1, ch, r.color);
          paint_block(cx, cy + ch - 1, cw, 1, r.color);
          paint_block(cx, cy, 1, ch, r.color);
        end
        shadow_dirty = 1'b1;
      end
      mfsf_pkg::CMD_RIGHT_TRI, mfsf_pkg::CMD_LEFT_TRI: begin
        half  = (ch >> 1) + 1;
        start = cy + half - ((ch & 1) == 0 ? 1 : 0);
        for (int unsigned i = 0; i < half; i++) begin
          if (r.cmd == mfsf_pkg::CMD_RIGHT_TRI) begin
            paint_block(cx + i, start - half + i + 1, 1, (half - i - 1) * 2 + 1, r.color);
          end else begin
            paint_block(cx + i, start - i, 1, 2 * i + 1, r.color);
          end
        end
        shadow_dirty = 1'b1;
      end
      mfsf_pkg::CMD_UP_TRI, mfsf_pkg::CMD_DOWN_TRI: begin
        hw = cw >> 1;
        for (int unsigned i = 0; i <= hw; i++) begin
          row = (r.cmd == mfsf_pkg::CMD_UP_TRI) ? cy + hw - i : cy + i;
          paint_block(cx + i, row, cw - 2 * i, 1, r.color);
        end
        shadow_dirty = 1'b1;
      end
      mfsf_pkg::CMD_READ: begin
        if (cx < FB_COLUMNS) res.word = shadow_fb[cx];
      end
      mfsf_pkg::CMD_ACK: begin
        shadow_dirty = 1'b0;
      end
      default: begin
      end
    endcase
    res.pending = shadow_dirty;
    return res;
  endfunction

  function automatic shape_req_t random_shape_req();
    shape_req_t  r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    // Clears are slow, so keep them rare; reads dominate the checks on the frame.
    if (sel < 3) r.cmd = mfsf_pkg::CMD_CLEAR;
    else if (sel < 53) r.cmd = 4'($urandom_range(mfsf_pkg::CMD_FILL, mfsf_pkg::CMD_DOWN_TRI));
    else if (sel < 85) r.cmd = mfsf_pkg::CMD_READ;
    else if (sel < 93) r.cmd = mfsf_pkg::CMD_ACK;
    else r.cmd = 4'($urandom_range(FIRST_UNUSED_CMD, LAST_UNUSED_CMD));
    r.x = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, FB_COLUMNS - 1)) : 8'($urandom);
    r.y = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, FB_ROWS - 1)) : 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 70) r.w = 8'($urandom_range(0, 24));
    else if (sel < 90) r.w = 8'($urandom_range(0, FB_COLUMNS));
    else r.w = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 70) r.h = 8'($urandom_range(0, 20));
    else if (sel < 90) r.h = 8'($urandom_range(0, FB_ROWS + 2));
    else r.h = 8'($urandom);
    r.color = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Entered on a falling edge; leaves on the falling edge after the transaction.
  // Valid is only lowered when an idle gap is taken, so it never drops and rises
  // again within one time step.
  task automatic offer_cmd(shape_req_t r, logic fixed, fb_result_t fixed_res);
    fb_result_t res;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    command_i  <= r.cmd;
    x_i        <= r.x;
    y_i        <= r.y;
    width_i    <= r.w;
    height_i   <= r.h;
    color_i    <= r.color;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_shape_cmd(r);
    if (fixed) res = fixed_res;
    column_results_q.push_back(res);
    if (r.cmd <= mfsf_pkg::CMD_DOWN_TRI) draw_count++;
    else if (r.cmd == mfsf_pkg::CMD_READ) read_count++;
    else if (r.cmd == mfsf_pkg::CMD_ACK) ack_count++;
    else unused_count++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (column_results_q.size() != 0);
  endtask

  task automatic add_row(logic [3:0] cmd, logic [7:0] x, logic [7:0] y, logic [7:0] w,
                         logic [7:0] h, logic color, logic fixed, logic [31:0] word,
                         logic pending);
    table_row_t row;
    row.req     = '{cmd: cmd, x: x, y: y, w: w, h: h, color: color};
    row.fixed   = fixed;
    row.result  = '{word: word, pending: pending};
    directed_q.push_back(row);
  endtask

  // Output side: ready follows the current idle rate, except for a requested hold-off,
  // which is counted here while the sender keeps offering transactions.
  initial begin : receiver
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
        hold_offs_done++;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    fb_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (column_results_q.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
          $display("unexpected result: word %h pending %b", column_word_o, refresh_pending_o);
        end
      end else begin
        want = column_results_q.pop_front();
        results_checked++;
        if (column_word_o !== want.word || refresh_pending_o !== want.pending) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("result %0d: expected word %h pending %b, got word %h pending %b",
                     results_checked, want.word, want.pending, column_word_o,
                     refresh_pending_o);
          end
        end
      end
    end
  end

  // Abort when neither channel has moved a transaction for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    command_i  = mfsf_pkg::CMD_CLEAR;
    x_i        = 8'h00;
    y_i        = 8'h00;
    width_i    = 8'h00;
    height_i   = 8'h00;
    color_i    = 1'b0;
    for (int unsigned c = 0; c < FB_COLUMNS; c++) shadow_fb[c] = 32'h0;
    shadow_dirty = 1'b0;

    // Directed table: reset state, reads past the edge, clears of both colours,
    // clipping at the corner, an empty outline, every triangle, unused code, acknowledge.
    add_row(mfsf_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_ACK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_READ, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_FILL, 8'd0, 8'd0, 8'd1, 8'd1, 1'b0, 1'b1, 32'h0, 1'b1);
    add_row(mfsf_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h8000_0000, 1'b1);
    add_row(mfsf_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h0, 1'b1);
    add_row(mfsf_pkg::CMD_READ, 8'd127, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1);
    add_row(mfsf_pkg::CMD_READ, 8'd128, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h0, 1'b1);
    add_row(mfsf_pkg::CMD_ACK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 32'h0, 1'b1);
    add_row(mfsf_pkg::CMD_READ, 8'd5, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h0, 1'b1);
    add_row(mfsf_pkg::CMD_FILL, 8'd120, 8'd28, 8'd255, 8'd255, 1'b0, 1'b0, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_READ, 8'd127, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h0000_000F, 1'b1);
    add_row(mfsf_pkg::CMD_OUTLINE, 8'd10, 8'd2, 8'd0, 8'd5, 1'b0, 1'b1, 32'h0, 1'b1);
    add_row(mfsf_pkg::CMD_OUTLINE, 8'd10, 8'd2, 8'd6, 8'd5, 1'b0, 1'b0, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_READ, 8'd10, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_RIGHT_TRI, 8'd20, 8'd3, 8'd0, 8'd6, 1'b0, 1'b0, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_READ, 8'd21, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_LEFT_TRI, 8'd30, 8'd250, 8'd0, 8'd255, 1'b0, 1'b0, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_UP_TRI, 8'd40, 8'd10, 8'd9, 8'd0, 1'b0, 1'b0, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_READ, 8'd44, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_DOWN_TRI, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_DOWN_TRI, 8'd50, 8'd20, 8'd8, 8'd0, 1'b1, 1'b0, 32'h0, 1'b0);
    add_row(mfsf_pkg::CMD_FILL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 32'h0, 1'b0);
    add_row(LAST_UNUSED_CMD, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 32'h0, 1'b1);
    add_row(mfsf_pkg::CMD_ACK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h0, 1'b0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Three idling profiles: slow receiver, slow sender, then flat out.
    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 17;
          recv_idle_pct   = 46;
        end
        1: begin
          sender_idle_pct = 46;
          recv_idle_pct   = 17;
        end
        default: begin
          sender_idle_pct = 0;
          recv_idle_pct   = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed_q[k]) begin
          offer_cmd(directed_q[k].req, directed_q[k].fixed, directed_q[k].result);
        end
      end
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Back up the engine behind a stalled output while input keeps coming (slow sender: drain).
        if (n == 120 && phase != 1) hold_off_req = 1'b1;
        if (n == 240 && phase == 1) pause_until_drained();
        offer_cmd(random_shape_req(), 1'b0, '0);
      end
      pause_until_drained();
    end

    // Allow any stray late result to show up before judging.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (column_results_q.size() != 0) begin
      fault_count++;
      $display("%0d results never arrived", column_results_q.size());
    end

    $display("Checked %0d results: %0d draw or clear, %0d reads, %0d acknowledges, %0d unused",
             results_checked, draw_count, read_count, ack_count, unused_count);
    $display("Idling profiles: 3, long output hold-offs: %0d, failures: %0d",
             hold_offs_done, fault_count);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mfsf_pkg.sv
rtl/mfsf_ram.sv
rtl/mfsf_sweep.sv
rtl/mfsf_rmw.sv
rtl/mono_framebuffer_shape_fill_core.sv
tb/tb_top.sv
